>>> hw/rtl/abmnn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abmnn_pkg
// shared types and constants of the adjacency bit matrix neighbor iterator
// ----------------------------------------------------------------------------
package abmnn_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned CNT_W  = 7;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // cursor status codes
  localparam logic [1:0] STAT_FRESH = 2'd0;
  localparam logic [1:0] STAT_VALID = 2'd1;
  localparam logic [1:0] STAT_DONE  = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] target;
  } abmnn_in_t;

  typedef struct packed {
    logic              found;
    logic [NODE_W-1:0] neighbor;
  } abmnn_out_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [NODE_W-1:0] pos;
  } abmnn_cur_t;

endpackage

>>> hw/rtl/adjacency_bit_matrix_next_neighbor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacency_bit_matrix_next_neighbor
// directed graph kept as a bit matrix, one row word per node, with a
// per-node cursor that steps through the set columns of its row
// ----------------------------------------------------------------------------
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid_i, in_ready_o, in_data_i  | to block
//  out     | out_valid_o, out_ready_i, out_data_o | from block
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_data_i | to block (node_count)
//
// one item per cycle sustained while the result register is not held; the
// accept edge reads the row word and cursor entry into stage 1, and stage 1
// writes back and loads the result register
// reset empties the matrix and cursor table at once through per-row valid bits
// a held result stalls stage 1, which in turn holds in_ready_o low
// back-to-back items on one node are covered by forwarding the write-back
// ----------------------------------------------------------------------------
module adjacency_bit_matrix_next_neighbor #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  abmnn_pkg::abmnn_in_t         in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output abmnn_pkg::abmnn_out_t        out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [abmnn_pkg::CNT_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned NW = abmnn_pkg::NODE_W;
  localparam int unsigned CW = abmnn_pkg::CNT_W;

  // storage: row words and cursor entries, valid bits stand in for reset
  logic [MAX_NODES-1:0]  row_mem [MAX_NODES];
  abmnn_pkg::abmnn_cur_t cur_mem [MAX_NODES];
  logic [MAX_NODES-1:0]  row_vld_q;
  logic [MAX_NODES-1:0]  cur_vld_q;

  // configuration
  logic [CW-1:0] node_count_q;
  logic [CW-1:0] cnt;

  // stage 1 registers
  logic                  s1_vld_q;
  abmnn_pkg::abmnn_in_t  s1_item_q;
  logic [MAX_NODES-1:0]  row_rd_q;
  abmnn_pkg::abmnn_cur_t cur_rd_q;
  logic                  row_rd_vld_q;
  logic                  cur_rd_vld_q;
  logic                  fwd_row_hit_q;
  logic                  fwd_cur_hit_q;
  logic [MAX_NODES-1:0]  fwd_row_q;
  abmnn_pkg::abmnn_cur_t fwd_cur_q;

  // result register
  logic                  out_vld_q;
  abmnn_pkg::abmnn_out_t out_data_q;

  // handshakes
  logic          adv;
  logic          in_acc;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] s1_addr;

  // stage 1 logic
  logic [MAX_NODES-1:0]  row_cur;
  abmnn_pkg::abmnn_cur_t cur_cur;
  logic                  in_range;
  logic                  row_we;
  logic [MAX_NODES-1:0]  row_new;
  logic                  cur_we;
  abmnn_pkg::abmnn_cur_t cur_new;
  logic [CW-1:0]         start;
  logic                  live;
  logic [MAX_NODES-1:0]  cand;
  logic                  hit;
  logic [NW-1:0]         col;
  abmnn_pkg::abmnn_out_t res;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = !s1_vld_q || adv;
  assign in_acc      = in_valid_i && in_ready_o;
  assign in_addr     = in_data_i.node[AW-1:0];
  assign s1_addr     = s1_item_q.node[AW-1:0];
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

  // live node count, saturated to the table size
  assign cnt = (node_count_q > CW'(MAX_NODES)) ? CW'(MAX_NODES) : node_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= abmnn_pkg::CNT_RESET;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // ---- stage 1: update of the row word or the cursor ----
  always_comb begin
    // forwarded write-back wins over the stale memory read
    if (fwd_row_hit_q) begin
      row_cur = fwd_row_q;
    end else if (row_rd_vld_q) begin
      row_cur = row_rd_q;
    end else begin
      row_cur = '0;
    end
    if (fwd_cur_hit_q) begin
      cur_cur = fwd_cur_q;
    end else if (cur_rd_vld_q) begin
      cur_cur = cur_rd_q;
    end else begin
      cur_cur = '0;
    end

    in_range = {1'b0, s1_item_q.node} < cnt;

    // insert: set the edge bit when the node and the target are in range
    row_we = s1_vld_q && in_range && (s1_item_q.operation == abmnn_pkg::OP_INSERT)
             && ({1'b0, s1_item_q.target} < cnt);
    for (int c = 0; c < MAX_NODES; c++) begin
      row_new[c] = row_cur[c] || (s1_item_q.target == NW'(c));
    end

    // query: scan resumes one past the cursor, or at column 0; a done cursor finds nothing
    case (cur_cur.status)
      abmnn_pkg::STAT_FRESH: begin
        start = '0;
        live  = 1'b1;
      end
      abmnn_pkg::STAT_VALID: begin
        start = {1'b0, cur_cur.pos} + CW'(1);
        live  = 1'b1;
      end
      default: begin
        start = '0;
        live  = 1'b0;
      end
    endcase

    for (int c = 0; c < MAX_NODES; c++) begin
      cand[c] = row_cur[c] && (CW'(c) >= start) && (CW'(c) < cnt);
    end

    // lowest candidate column
    hit = 1'b0;
    col = '0;
    for (int c = MAX_NODES - 1; c >= 0; c--) begin
      if (cand[c]) begin
        hit = 1'b1;
        col = NW'(c);
      end
    end

    cur_we = s1_vld_q && in_range && (s1_item_q.operation == abmnn_pkg::OP_QUERY) && live;
    if (hit) begin
      cur_new.status = abmnn_pkg::STAT_VALID;
      cur_new.pos    = col;
    end else begin
      cur_new.status = abmnn_pkg::STAT_DONE;
      cur_new.pos    = cur_cur.pos;
    end

    res.found    = cur_we && hit;
    res.neighbor = (cur_we && hit) ? col : '0;
  end

  // ---- memories: read on accept, write on stage 1 commit ----
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_rd_q <= row_mem[in_addr];
      cur_rd_q <= cur_mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_we && adv) begin
      row_mem[s1_addr] <= row_new;
    end
    if (cur_we && adv) begin
      cur_mem[s1_addr] <= cur_new;
    end
  end

  // per-entry valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      cur_vld_q <= '0;
    end else begin
      if (row_we && adv) begin
        row_vld_q[s1_addr] <= 1'b1;
      end
      if (cur_we && adv) begin
        cur_vld_q[s1_addr] <= 1'b1;
      end
    end
  end

  // stage 1 control and forwarding flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q      <= 1'b0;
      row_rd_vld_q  <= 1'b0;
      cur_rd_vld_q  <= 1'b0;
      fwd_row_hit_q <= 1'b0;
      fwd_cur_hit_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_vld_q <= in_valid_i;
      if (in_valid_i) begin
        row_rd_vld_q  <= row_vld_q[in_addr];
        cur_rd_vld_q  <= cur_vld_q[in_addr];
        // same node written back at this edge: memory read is stale
        fwd_row_hit_q <= row_we && adv && (s1_item_q.node == in_data_i.node);
        fwd_cur_hit_q <= cur_we && adv && (s1_item_q.node == in_data_i.node);
      end
    end
  end

  // forwarded data, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_data_i;
      fwd_row_q <= row_new;
      fwd_cur_q <= cur_new;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_vld_q) begin
      out_data_q <= res;
    end
  end

endmodule
